[hdl/hdlcf_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hdlcf_pkg: shared types and constants of the async HDLC framer
// Word layouts of the request and response channels, the framer state
// record, line constants and the FCS-16 byte update.
// ----------------------------------------------------------------------------
package hdlcf_pkg;

   // Line constants
   localparam logic [7:0]  FLAG_BYTE = 8'h7E;
   localparam logic [7:0]  ESC_BYTE  = 8'h7D;
   localparam logic [7:0]  XOR_BYTE  = 8'h20;
   localparam logic [15:0] FCS_POLY  = 16'h8408;
   localparam logic [15:0] FCS_INIT  = 16'hFFFF;
   localparam logic [15:0] CAP_RESET = 16'hFFFF;

   // Most response words that one request word can cause
   localparam int MAX_RESULTS = 8;
   localparam int RES_IDX_W   = $clog2(MAX_RESULTS);
   localparam int RES_CNT_W   = $clog2(MAX_RESULTS + 1);

   // Request word: one payload byte
   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_of_frame;
   } req_type;

   // Response word: one line byte
   typedef struct packed {
      logic [7:0] out_byte;
      logic       last_of_run;
      logic       frame_done;
      logic       overflow;
   } rsp_type;

   // Framer state carried from word to word
   typedef struct packed {
      logic [15:0] running_crc;
      logic        in_frame;
      logic [16:0] emitted_count;
      logic        dropping;
   } fr_state_type;

   localparam fr_state_type STATE_RESET = '{
      running_crc:   FCS_INIT,
      in_frame:      1'b0,
      emitted_count: 17'd0,
      dropping:      1'b0
   };

   // Reflected CRC-16-CCITT update over one byte, LSB first
   function automatic logic [15:0] fcs_byte(input logic [15:0] crc,
                                            input logic [7:0]  b);
      logic [15:0] c;
      c = crc ^ {8'h00, b};
      for (int k = 0; k < 8; k++) begin
         if (c[0]) begin
            c = (c >> 1) ^ FCS_POLY;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

   // Bytes sent as escape plus byte^0x20
   function automatic logic needs_escape(input logic [7:0] b);
      return (b < XOR_BYTE) || (b == FLAG_BYTE) || (b == ESC_BYTE);
   endfunction

endpackage
`default_nettype wire

[hdl/hdlc_async_framer_fcs16.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hdlc_async_framer_fcs16: octet-stuffed HDLC framer with FCS-16
// Payload bytes in, flagged and escaped line bytes out, with the
// complemented FCS-16 and a closing flag after the last byte of a frame.
// ----------------------------------------------------------------------------
// A payload word is held in an input register, framed in one pass into a
// run of 0 to 8 line bytes, and that run is sent one byte per cycle on the
// response port while rsp_stall is low. A plain data byte causes one line
// byte, an escaped one two, and an escaped last byte with its FCS and flags
// up to 8; a word that causes no byte (the rest of an aborted frame) gives
// an empty run. The next word is framed in the cycle the final byte of the
// current run is taken, so back-to-back runs leave no gap. The single-byte
// output port sets the rate. frame_capacity is to be written on the csr port
// only while the block is idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module hdlc_async_framer_fcs16 (
   input  wire                        clock,
   input  wire                        reset,
   // payload words
   input  wire                        req_valid,
   output logic                       req_stall,
   input  wire hdlcf_pkg::req_type    req_data,
   // line byte words
   output logic                       rsp_valid,
   input  wire                        rsp_stall,
   output hdlcf_pkg::rsp_type         rsp_data,
   // capacity register
   input  wire                        csr_valid,
   output logic                       csr_ready,
   input  wire [15:0]                 csr_data
);

   hdlcf_pkg::fr_state_type                         state_ff, state_in;
   logic [15:0]                                     cap_ff;
   logic                                            in_valid_ff;
   hdlcf_pkg::req_type                              in_data_ff;
   hdlcf_pkg::rsp_type [hdlcf_pkg::MAX_RESULTS-1:0] res_ff, res_in;
   logic [hdlcf_pkg::RES_CNT_W-1:0]                 left_ff, count_in;
   logic [hdlcf_pkg::RES_IDX_W-1:0]                 idx_ff;
   logic                                            pop;
   logic                                            load;

   // framing logic for the held word
   hdlcf_encode u_encode (
      .state_i    (state_ff),
      .capacity_i (cap_ff),
      .req_i      (in_data_ff),
      .res_o      (res_in),
      .count_o    (count_in),
      .state_o    (state_in)
   );

   // output side handshake
   assign rsp_valid = (left_ff != '0);
   assign rsp_data  = res_ff[idx_ff];
   assign pop       = rsp_valid && !rsp_stall;
   assign load      = in_valid_ff &&
                      ((left_ff == '0) || (left_ff == hdlcf_pkg::RES_CNT_W'(1) && pop));
   assign req_stall = in_valid_ff && !load;
   assign csr_ready = 1'b1;

   // capacity register
   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff <= hdlcf_pkg::CAP_RESET;
      end else if (csr_valid && csr_ready) begin
         cap_ff <= csr_data;
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_valid && !req_stall) begin
         in_valid_ff <= 1'b1;
      end else if (load) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_data_ff <= req_data;
      end
   end

   // framer state and run buffer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= hdlcf_pkg::STATE_RESET;
         left_ff  <= '0;
         idx_ff   <= '0;
      end else if (load) begin
         state_ff <= state_in;
         left_ff  <= count_in;
         idx_ff   <= '0;
      end else if (pop) begin
         left_ff  <= left_ff - 1'b1;
         idx_ff   <= idx_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         res_ff <= res_in;
      end
   end

endmodule
`default_nettype wire

[hdl/hdlcf_encode.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hdlcf_encode: framing step for one payload byte
// From the current framer state and one payload byte, builds the list of
// line bytes (flag, escaped data, escaped FCS, closing flag or overflow)
// and the framer state that follows.
// ----------------------------------------------------------------------------
module hdlcf_encode (
   input  wire hdlcf_pkg::fr_state_type                         state_i,
   input  wire [15:0]                                           capacity_i,
   input  wire hdlcf_pkg::req_type                              req_i,
   output hdlcf_pkg::rsp_type [hdlcf_pkg::MAX_RESULTS-1:0]      res_o,
   output logic [hdlcf_pkg::RES_CNT_W-1:0]                      count_o,
   output hdlcf_pkg::fr_state_type                              state_o
);

   logic [hdlcf_pkg::RES_CNT_W-1:0] k;
   logic [16:0]                     e;
   logic [15:0]                     crc_base;
   logic [15:0]                     crc_new;
   logic [15:0]                     fcs;
   logic                            ok;
   logic [1:0]                      nsend;
   logic [2:0][7:0]                 send_bytes;

   // FCS over the new byte, starting fresh on the first byte of a frame
   assign crc_base = state_i.in_frame ? state_i.running_crc : hdlcf_pkg::FCS_INIT;
   assign crc_new  = hdlcf_pkg::fcs_byte(crc_base, req_i.data_byte);
   assign fcs      = ~crc_new;

   always_comb begin
      res_o         = '0;
      k             = '0;
      e             = state_i.emitted_count;
      ok            = 1'b1;
      state_o       = state_i;
      send_bytes[0] = req_i.data_byte;
      send_bytes[1] = fcs[7:0];
      send_bytes[2] = fcs[15:8];
      nsend         = req_i.last_of_frame ? 2'd3 : 2'd1;

      if (state_i.dropping) begin
         // rest of an aborted frame: silent, back to idle on its last byte
         if (req_i.last_of_frame) begin
            state_o.in_frame      = 1'b0;
            state_o.dropping      = 1'b0;
            state_o.emitted_count = '0;
         end
      end else begin
         // opening flag
         if (!state_i.in_frame) begin
            res_o[k[hdlcf_pkg::RES_IDX_W-1:0]].out_byte = hdlcf_pkg::FLAG_BYTE;
            k = k + 1'b1;
            e = 17'd1;
         end

         // data byte, then FCS low and high on the last byte
         for (int j = 0; j < 3; j++) begin
            if (ok && (2'(j) < nsend)) begin
               if ({1'b0, capacity_i} < e + 17'd3) begin
                  res_o[k[hdlcf_pkg::RES_IDX_W-1:0]].overflow = 1'b1;
                  k  = k + 1'b1;
                  ok = 1'b0;
               end else if (hdlcf_pkg::needs_escape(send_bytes[j])) begin
                  res_o[k[hdlcf_pkg::RES_IDX_W-1:0]].out_byte = hdlcf_pkg::ESC_BYTE;
                  k = k + 1'b1;
                  res_o[k[hdlcf_pkg::RES_IDX_W-1:0]].out_byte =
                     send_bytes[j] ^ hdlcf_pkg::XOR_BYTE;
                  k = k + 1'b1;
                  e = e + 17'd2;
               end else begin
                  res_o[k[hdlcf_pkg::RES_IDX_W-1:0]].out_byte = send_bytes[j];
                  k = k + 1'b1;
                  e = e + 17'd1;
               end
            end
         end

         // closing flag
         if (ok && req_i.last_of_frame) begin
            res_o[k[hdlcf_pkg::RES_IDX_W-1:0]].out_byte   = hdlcf_pkg::FLAG_BYTE;
            res_o[k[hdlcf_pkg::RES_IDX_W-1:0]].frame_done = 1'b1;
            k = k + 1'b1;
         end

         // next state
         if (req_i.last_of_frame) begin
            state_o.in_frame      = 1'b0;
            state_o.dropping      = 1'b0;
            state_o.emitted_count = '0;
            state_o.running_crc   = crc_new;
         end else if (!ok) begin
            state_o.in_frame = 1'b0;
            state_o.dropping = 1'b1;
         end else begin
            state_o.in_frame      = 1'b1;
            state_o.emitted_count = e;
            state_o.running_crc   = crc_new;
         end
      end

      // mark the final word of the run
      for (int i = 0; i < hdlcf_pkg::MAX_RESULTS; i++) begin
         res_o[i].last_of_run = (k != '0) && (hdlcf_pkg::RES_CNT_W'(i) == k - 1'b1);
      end
   end

   assign count_o = k;

endmodule
`default_nettype wire

[sim/hdlc_async_framer_fcs16_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hdlc_async_framer_fcs16_tb: self-checking bench for the async HDLC framer
// Sends payload words, predicts every line byte (flags, escapes, FCS-16,
// capacity aborts) with an internal framer model and checks each response
// word in order. Capacity is rewritten between phases while the block is idle.
// ----------------------------------------------------------------------------
module hdlc_async_framer_fcs16_tb;

   localparam int CLK_HALF     = 5;
   localparam int SETTLE_TICKS = 24;       // words that yield no byte still take cycles
   localparam int CYCLE_LIMIT  = 600000;
   localparam int RANDOM_WORDS = 92;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   hdlcf_pkg::req_type req_data = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   hdlcf_pkg::rsp_type rsp_data;
   logic               csr_valid = 1'b0;
   logic               csr_ready;
   logic [15:0]        csr_data = 16'h0000;

   hdlc_async_framer_fcs16 dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   initial begin
      forever #CLK_HALF clock = ~clock;
   end

   // Framer model state
   logic [15:0] frame_cap  = hdlcf_pkg::CAP_RESET;
   logic [15:0] fcs_acc    = hdlcf_pkg::FCS_INIT;
   logic        framing    = 1'b0;
   int unsigned line_count = 0;
   logic        discarding = 1'b0;

   // Line bytes still owed by the block, oldest first
   hdlcf_pkg::rsp_type line_bytes_q[$];

   // Run bookkeeping
   int  err_count     = 0;
   int  cycle_count   = 0;
   int  words_sent    = 0;
   int  bytes_checked = 0;
   int  frames_closed = 0;
   int  aborts_seen   = 0;
   int  cap_writes    = 0;
   bit  quiet         = 1'b0;   // no idling on either side while set
   int  stall_left    = 0;
   hdlcf_pkg::rsp_type want;

   // Reflected CRC-16-CCITT, one bit per pass
   function automatic logic [15:0] fcs16_update(input logic [15:0] acc,
                                                input logic [7:0]  b);
      logic [15:0] a;
      a = acc ^ {8'h00, b};
      for (int k = 0; k < 8; k++) begin
         a = (a >> 1) ^ (a[0] ? hdlcf_pkg::FCS_POLY : 16'h0000);
      end
      return a;
   endfunction

   function automatic void owe_byte(input logic [7:0] b, input logic done,
                                    input logic ovf);
      hdlcf_pkg::rsp_type w;
      w.out_byte    = b;
      w.last_of_run = 1'b0;
      w.frame_done  = done;
      w.overflow    = ovf;
      line_bytes_q.push_back(w);
   endfunction

   // One payload or FCS byte with capacity check; 0 means the frame aborted
   function automatic bit stuff_byte(input logic [7:0] c);
      if (int'(frame_cap) < line_count + 3) begin
         owe_byte(8'h00, 1'b0, 1'b1);
         return 1'b0;
      end
      if (c < hdlcf_pkg::XOR_BYTE || c == hdlcf_pkg::FLAG_BYTE ||
          c == hdlcf_pkg::ESC_BYTE) begin
         owe_byte(hdlcf_pkg::ESC_BYTE, 1'b0, 1'b0);
         owe_byte(c ^ hdlcf_pkg::XOR_BYTE, 1'b0, 1'b0);
         line_count += 2;
      end else begin
         owe_byte(c, 1'b0, 1'b0);
         line_count += 1;
      end
      return 1'b1;
   endfunction

   function automatic void back_to_idle();
      framing    = 1'b0;
      discarding = 1'b0;
      line_count = 0;
   endfunction

   // Expected line bytes for one accepted payload word; returns their number
   function automatic int frame_word(input logic [7:0] c, input logic last);
      int          first;
      int          n;
      logic [15:0] fcs;
      first = line_bytes_q.size();
      if (discarding) begin
         if (last) back_to_idle();
         return 0;
      end
      if (!framing) begin
         framing = 1'b1;
         fcs_acc = hdlcf_pkg::FCS_INIT;
         owe_byte(hdlcf_pkg::FLAG_BYTE, 1'b0, 1'b0);
         line_count = 1;
      end
      if (!stuff_byte(c)) begin
         if (last) begin
            back_to_idle();
         end else begin
            framing    = 1'b0;
            discarding = 1'b1;
         end
      end else begin
         fcs_acc = fcs16_update(fcs_acc, c);
         if (last) begin
            fcs = ~fcs_acc;
            if (stuff_byte(fcs[7:0])) begin
               if (stuff_byte(fcs[15:8])) owe_byte(hdlcf_pkg::FLAG_BYTE, 1'b1, 1'b0);
            end
            back_to_idle();
         end
      end
      n = line_bytes_q.size() - first;
      if (n > 0) line_bytes_q[line_bytes_q.size() - 1].last_of_run = 1'b1;
      return n;
   endfunction

   // Idle lengths: mostly short, a few long
   function automatic int pick_gap();
      int r;
      if (quiet) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   // Payload value biased toward bytes that need escaping
   function automatic logic [7:0] pick_byte();
      case ($urandom_range(0, 9))
         0:       return 8'($urandom_range(0, 31));
         1:       return hdlcf_pkg::FLAG_BYTE;
         2:       return hdlcf_pkg::ESC_BYTE;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   // Response side back-pressure
   always @(posedge clock) begin
      if (reset || quiet) begin
         stall_left = 0;
         rsp_stall <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left = stall_left - 1;
         rsp_stall <= 1'b1;
      end else if ($urandom_range(0, 99) < 30) begin
         stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30) : $urandom_range(0, 2);
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // Compare each accepted line byte with the oldest one owed
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (line_bytes_q.size() == 0) begin
            $error("unexpected line byte %h", rsp_data.out_byte);
            err_count++;
         end else begin
            want = line_bytes_q.pop_front();
            bytes_checked++;
            if (rsp_data.out_byte !== want.out_byte) begin
               $error("out_byte: expected %h, got %h", want.out_byte, rsp_data.out_byte);
               err_count++;
            end
            if (rsp_data.last_of_run !== want.last_of_run) begin
               $error("last_of_run: expected %b, got %b", want.last_of_run,
                      rsp_data.last_of_run);
               err_count++;
            end
            if (rsp_data.frame_done !== want.frame_done) begin
               $error("frame_done: expected %b, got %b", want.frame_done,
                      rsp_data.frame_done);
               err_count++;
            end
            if (rsp_data.overflow !== want.overflow) begin
               $error("overflow: expected %b, got %b", want.overflow, rsp_data.overflow);
               err_count++;
            end
            if (want.frame_done) frames_closed++;
            if (want.overflow) aborts_seen++;
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $error("timeout after %0d cycles, %0d line bytes outstanding", cycle_count,
                line_bytes_q.size());
         $display("simulation failed");
         $finish;
      end
   end

   // Send one payload word; valid stays high after acceptance until the
   // next word or an explicit idle, so back-to-back words never glitch it
   task automatic send_word(input logic [7:0] b, input logic last);
      int                 gap;
      hdlcf_pkg::req_type w;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      w.data_byte     = b;
      w.last_of_frame = last;
      req_valid <= 1'b1;
      req_data  <= w;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      void'(frame_word(b, last));
      words_sent++;
   endtask

   // Stop sending and wait until every owed byte is back and the block settles
   task automatic drain_block();
      req_valid <= 1'b0;
      @(posedge clock);
      while (line_bytes_q.size() != 0) @(posedge clock);
      repeat (SETTLE_TICKS) @(posedge clock);
   endtask

   task automatic write_capacity(input logic [15:0] v);
      drain_block();
      csr_valid <= 1'b1;
      csr_data  <= v;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      frame_cap = v;
      cap_writes++;
   endtask

   // Escaping of every special class, full byte range, one-byte frame
   task automatic test_escaping();
      write_capacity(16'hFFFF);
      send_word(8'h00, 1'b0);
      send_word(8'h1F, 1'b0);
      send_word(8'h20, 1'b0);
      send_word(hdlcf_pkg::ESC_BYTE, 1'b0);
      send_word(hdlcf_pkg::FLAG_BYTE, 1'b0);
      send_word(8'hFF, 1'b0);
      send_word(8'h80, 1'b1);
      send_word(hdlcf_pkg::FLAG_BYTE, 1'b1);
   endtask

   // Aborts mid-frame, on the last byte and inside the FCS
   task automatic test_capacity_abort();
      write_capacity(16'd4);
      // mid-frame abort, then the rest of the frame is swallowed
      send_word(8'h41, 1'b0);
      send_word(8'h42, 1'b0);
      send_word(8'h43, 1'b0);
      send_word(8'h44, 1'b1);
      // abort on the last payload byte
      send_word(8'h41, 1'b0);
      send_word(8'h42, 1'b1);
      // escaped byte fits, FCS does not
      send_word(8'h00, 1'b1);
   endtask

   // Capacities below the minimum: flag goes out, overflow follows at once
   task automatic test_tiny_capacity();
      write_capacity(16'd0);
      send_word(8'h55, 1'b1);
      write_capacity(16'd3);
      send_word(8'h55, 1'b0);
      send_word(8'h10, 1'b1);
   endtask

   // Random frames over several capacity settings
   task automatic test_random_frames();
      int          phase;
      int          phase_words;
      int          len;
      int          n;
      logic [15:0] cap;
      logic [7:0]  b;
      int          done_words;
      phase = 0;
      done_words = 0;
      while (done_words < RANDOM_WORDS) begin
         case (phase % 5)
            0:       cap = 16'hFFFF;
            1:       cap = 16'($urandom_range(4, 12));
            2:       cap = 16'($urandom_range(13, 40));
            3:       cap = 16'd4;
            default: cap = 16'($urandom_range(41, 65535));
         endcase
         write_capacity(cap);
         quiet = (phase == 2);
         phase_words = 0;
         while (phase_words < 18 && done_words < RANDOM_WORDS) begin
            len = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 16) : $urandom_range(1, 5);
            if (len > RANDOM_WORDS - done_words) len = RANDOM_WORDS - done_words;
            for (int i = 0; i < len; i++) begin
               b = pick_byte();
               send_word(b, i == len - 1);
               phase_words++;
               done_words++;
            end
            // halfway through a phase, hold off until the output is empty
            if (phase_words >= 9 && phase_words - len < 9) drain_block();
         end
         quiet = 1'b0;
         phase++;
      end
      n = phase;
      $display("random part: %0d words over %0d capacity phases", done_words, n);
   endtask

   task automatic finish_run();
      drain_block();
      $display("covered %0d payload words, %0d line bytes, %0d closed frames, %0d aborts",
               words_sent, bytes_checked, frames_closed, aborts_seen);
      $display("capacity written %0d times, %0d mismatches", cap_writes, err_count);
      if (err_count == 0 && line_bytes_q.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_escaping();
      test_capacity_abort();
      test_tiny_capacity();
      test_random_frames();
      finish_run();
   end

endmodule
